/* sv/cgd_pkg.sv */
// Package for the chatter-gated debouncer: widths, register indexes,
// configuration and result structs, and the small helper functions.
// No dependencies.
package cgd_pkg;

  localparam int unsigned HIST_W     = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX  = 8'hFF;
  localparam logic [HIST_W-1:0] HIST_ONES = 8'hFF;
  localparam logic [3:0]        WIN_MAX  = 4'd8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_LIMIT      = 3'd0,
    REG_CHATTER_CONFIRM = 3'd1,
    REG_RECENTER_TICKS  = 3'd2,
    REG_WINDOW_LEN      = 3'd3,
    REG_START_LEVEL     = 3'd4
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [3:0]       RST_EDGE_LIMIT      = 4'd3;
  localparam logic [CNT_W-1:0] RST_CHATTER_CONFIRM = 8'd2;
  localparam logic [CNT_W-1:0] RST_RECENTER_TICKS  = 8'd50;
  localparam logic [3:0]       RST_WINDOW_LEN      = 4'd4;
  localparam logic             RST_START_LEVEL     = 1'b0;

  typedef struct packed {
    logic [3:0]       edge_limit;
    logic [CNT_W-1:0] chatter_confirm;
    logic [CNT_W-1:0] recenter_ticks;
    logic [3:0]       window_len;
    logic             start_level;
  } cfg_t;

  // Level reload request from the register file
  typedef struct packed {
    logic load;
    logic level;
  } level_load_t;

  typedef struct packed {
    logic              debounced_level;
    logic              pressed_pulse;
    logic              released_pulse;
    logic [HIST_W-1:0] history_bits;
  } result_t;

  // Number of level changes between the seven adjacent bit pairs
  function automatic logic [2:0] count_edges(input logic [HIST_W-1:0] h);
    logic [HIST_W-2:0] d;
    logic [2:0]        c;
    d = h[HIST_W-2:0] ^ h[HIST_W-1:1];
    c = '0;
    for (int i = 0; i < HIST_W - 1; i++) begin
      c = c + 3'(d[i]);
    end
    return c;
  endfunction

  // Window mask of the newest n samples, n above eight taken as eight
  function automatic logic [HIST_W-1:0] window_mask(input logic [3:0] n);
    logic [3:0] n_eff;
    n_eff = (n > WIN_MAX) ? WIN_MAX : n;
    return ~(HIST_ONES << n_eff);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

/* sv/cgd_sample_if.sv */
// Input channel of the debouncer: one raw switch sample per word.
// Depends on nothing.
interface cgd_sample_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink   (input valid, input raw_level, output ready);
endinterface

/* sv/cgd_result_if.sv */
// Output channel of the debouncer: level, pulses and history per word.
// Depends on nothing.
interface cgd_result_if;
  logic       valid;
  logic       ready;
  logic       debounced_level;
  logic       pressed_pulse;
  logic       released_pulse;
  logic [7:0] history_bits;

  modport source (output valid, output debounced_level, output pressed_pulse,
                  output released_pulse, output history_bits, input ready);
  modport sink   (input valid, input debounced_level, input pressed_pulse,
                  input released_pulse, input history_bits, output ready);
endinterface

/* sv/cgd_cfg_regs.sv */
// Configuration register file of the debouncer; a write to start_level
// also issues a level reload to the core. Depends on cgd_pkg.
module cgd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cgd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cgd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cgd_pkg::cfg_t                    cfg,
  output cgd_pkg::level_load_t             level_load
);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_limit      <= cgd_pkg::RST_EDGE_LIMIT;
      cfg.chatter_confirm <= cgd_pkg::RST_CHATTER_CONFIRM;
      cfg.recenter_ticks  <= cgd_pkg::RST_RECENTER_TICKS;
      cfg.window_len      <= cgd_pkg::RST_WINDOW_LEN;
      cfg.start_level     <= cgd_pkg::RST_START_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        cgd_pkg::REG_EDGE_LIMIT:      cfg.edge_limit      <= cfg_data[3:0];
        cgd_pkg::REG_CHATTER_CONFIRM: cfg.chatter_confirm <= cfg_data;
        cgd_pkg::REG_RECENTER_TICKS:  cfg.recenter_ticks  <= cfg_data;
        cgd_pkg::REG_WINDOW_LEN:      cfg.window_len      <= cfg_data[3:0];
        cgd_pkg::REG_START_LEVEL:     cfg.start_level     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Level reload goes to the core in the same cycle as the write
  always_comb begin
    level_load.load  = cfg_we && (cfg_index == cgd_pkg::REG_START_LEVEL);
    level_load.level = cfg_data[0];
  end

endmodule

/* sv/cgd_core.sv */
// Debouncer state (history, chatter and unstable counters, level) and the
// one-tick update logic. Depends on cgd_pkg.
module cgd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  cgd_pkg::cfg_t        cfg,
  input  cgd_pkg::level_load_t level_load,
  input  logic                 step,
  input  logic                 raw_level,
  output cgd_pkg::result_t     result
);

  logic [cgd_pkg::HIST_W-1:0] sample_history, sample_history_next;
  logic [cgd_pkg::CNT_W-1:0]  chatter_run, chatter_run_next;
  logic [cgd_pkg::CNT_W-1:0]  unstable_run, unstable_run_next;
  logic                       accepted_level, accepted_level_next;

  logic [cgd_pkg::HIST_W-1:0] hist_sh;
  logic [cgd_pkg::HIST_W-1:0] mask;
  logic [cgd_pkg::CNT_W-1:0]  chat_upd, uns_upd;
  logic                       chattering, confirmed, timeout;
  logic                       pressed, released;

  // One tick of the debouncer
  always_comb begin
    hist_sh    = {sample_history[cgd_pkg::HIST_W-2:0], raw_level};
    chattering = {1'b0, cgd_pkg::count_edges(hist_sh)} >= cfg.edge_limit;
    chat_upd   = chattering ? cgd_pkg::sat_inc(chatter_run) : '0;
    confirmed  = chat_upd >= cfg.chatter_confirm;
    uns_upd    = confirmed ? cgd_pkg::sat_inc(unstable_run) : '0;
    timeout    = uns_upd >= cfg.recenter_ticks;
    mask       = cgd_pkg::window_mask(cfg.window_len);

    sample_history_next = hist_sh;
    chatter_run_next    = chat_upd;
    unstable_run_next   = uns_upd;
    accepted_level_next = accepted_level;
    pressed             = 1'b0;
    released            = 1'b0;

    if (timeout) begin
      // recenter history on the debounced level, no event
      sample_history_next = accepted_level ? cgd_pkg::HIST_ONES : '0;
      chatter_run_next    = '0;
      unstable_run_next   = '0;
    end else if (!confirmed) begin
      if (!accepted_level && ((hist_sh & mask) == mask)) begin
        accepted_level_next = 1'b1;
        pressed             = 1'b1;
      end else if (accepted_level && ((hist_sh & mask) == '0)) begin
        accepted_level_next = 1'b0;
        released            = 1'b1;
      end
    end

    result.debounced_level = accepted_level_next;
    result.pressed_pulse   = pressed;
    result.released_pulse  = released;
    result.history_bits    = sample_history_next;
  end

  // State registers; reset and level reload fill the history with the level
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_history <= '0;
      chatter_run    <= '0;
      unstable_run   <= '0;
      accepted_level <= cgd_pkg::RST_START_LEVEL;
    end else if (level_load.load) begin
      sample_history <= level_load.level ? cgd_pkg::HIST_ONES : '0;
      chatter_run    <= '0;
      unstable_run   <= '0;
      accepted_level <= level_load.level;
    end else if (step) begin
      sample_history <= sample_history_next;
      chatter_run    <= chatter_run_next;
      unstable_run   <= unstable_run_next;
      accepted_level <= accepted_level_next;
    end
  end

endmodule

/* sv/chatter_gated_debouncer_unit.sv */
// Top level of the chatter-gated debouncer: input sample register, core
// and result register. Depends on cgd_pkg, cgd_sample_if, cgd_result_if,
// cgd_cfg_regs and cgd_core.
//
//  port      | dir | word contents
//  ----------+-----+------------------------------------------------------
//  samples   | in  | raw_level
//  results   | out | debounced_level, pressed_pulse, released_pulse,
//            |     | history_bits
//  cfg_*     | in  | write enable, register index, write data (no wait)
//
// One word per cycle sustained while results is not stalled; a sample taken
// into the input register is processed by the core and its result word is
// loaded into the result register, from which results presents it.
// Reset (rst, synchronous) loads the default registers and a released level.
// A stall on results holds the result register and the input register;
// samples stays ready while either register has room.
module chatter_gated_debouncer_unit (
  input  logic                           clk,
  input  logic                           rst,
  cgd_sample_if.sink                     samples,
  cgd_result_if.source                   results,
  input  logic                           cfg_we,
  input  logic [cgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgd_pkg::CFG_DATA_W-1:0] cfg_data
);

  cgd_pkg::cfg_t        cfg;
  cgd_pkg::level_load_t level_load;
  cgd_pkg::result_t     core_result;
  cgd_pkg::result_t     out_word;

  logic s1_valid;
  logic s1_raw;
  logic out_valid;
  logic advance;

  cgd_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .level_load (level_load)
  );

  cgd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .level_load (level_load),
    .step       (s1_valid && advance),
    .raw_level  (s1_raw),
    .result     (core_result)
  );

  // Flow control: result register frees when empty or taken
  assign advance       = !out_valid || results.ready;
  assign samples.ready = !s1_valid || advance;

  // Input sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      s1_raw <= samples.raw_level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_word <= core_result;
    end
  end

  assign results.valid           = out_valid;
  assign results.debounced_level = out_word.debounced_level;
  assign results.pressed_pulse   = out_word.pressed_pulse;
  assign results.released_pulse  = out_word.released_pulse;
  assign results.history_bits    = out_word.history_bits;

endmodule

/* verif/tb_chatter_gated_debouncer_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for chatter_gated_debouncer_unit: random raw samples
// with bursts of chatter, a debouncer predictor and a word checker.
// Depends on cgd_pkg, cgd_sample_if, cgd_result_if and the RTL top level.
module tb_chatter_gated_debouncer_unit;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [cgd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cgd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  cgd_sample_if sample_if ();
  cgd_result_if result_if ();

  chatter_gated_debouncer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (sample_if.sink),
    .results   (result_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Raw samples waiting for the driver, predicted words waiting for the block
  logic             raw_samples[$];
  cgd_pkg::result_t predicted_words[$];

  int   err_count = 0;
  int   src_gap = 0;
  int   snk_gap = 0;
  logic idle_on = 1'b1;
  logic sink_hold = 1'b0;

  // Predictor copy of the registers
  logic [3:0] thr_cfg     = cgd_pkg::RST_EDGE_LIMIT;
  logic [7:0] confirm_cfg = cgd_pkg::RST_CHATTER_CONFIRM;
  logic [7:0] timeout_cfg = cgd_pkg::RST_RECENTER_TICKS;
  logic [3:0] window_cfg  = cgd_pkg::RST_WINDOW_LEN;

  // Predictor copy of the debouncer state
  logic [7:0] hist_st      = 8'h00;
  logic [7:0] chatter_cnt  = 8'd0;
  logic [7:0] unstable_cnt = 8'd0;
  logic       level_st     = 1'b0;

  // Level reset: history filled with the level, both run counters cleared
  function automatic void load_level(input logic lvl);
    level_st     = lvl;
    hist_st      = lvl ? 8'hFF : 8'h00;
    chatter_cnt  = 8'd0;
    unstable_cnt = 8'd0;
  endfunction

  // One tick of the debouncer; returns the word it should produce
  function automatic cgd_pkg::result_t debounce_tick(input logic raw);
    cgd_pkg::result_t r;
    int               edges;
    logic             confirmed;
    logic [7:0]       mask;
    r = '0;
    hist_st = {hist_st[6:0], raw};
    edges = $countones((hist_st ^ (hist_st >> 1)) & 8'h7F);
    if (edges >= thr_cfg) begin
      if (chatter_cnt != 8'hFF) chatter_cnt = chatter_cnt + 8'd1;
    end else begin
      chatter_cnt = 8'd0;
    end
    confirmed = (chatter_cnt >= confirm_cfg);
    if (confirmed) begin
      if (unstable_cnt != 8'hFF) unstable_cnt = unstable_cnt + 8'd1;
    end else begin
      unstable_cnt = 8'd0;
    end
    if (unstable_cnt >= timeout_cfg) begin
      // recenter on the debounced level, no event
      hist_st      = level_st ? 8'hFF : 8'h00;
      unstable_cnt = 8'd0;
      chatter_cnt  = 8'd0;
    end else if (!confirmed) begin
      mask = (window_cfg >= 4'd8) ? 8'hFF : 8'((1 << window_cfg) - 1);
      if (!level_st && (hist_st & mask) == mask) begin
        level_st = 1'b1;
        r.pressed_pulse = 1'b1;
      end else if (level_st && (hist_st & mask) == 8'h00) begin
        level_st = 1'b0;
        r.released_pulse = 1'b1;
      end
    end
    r.debounced_level = level_st;
    r.history_bits    = hist_st;
    return r;
  endfunction

  function automatic void log_mismatch(input string what, input cgd_pkg::result_t want,
                                       input cgd_pkg::result_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t %s: exp lvl=%0b prs=%0b rel=%0b h=%02h, act lvl=%0b prs=%0b rel=%0b h=%02h",
               $realtime, what, want.debounced_level, want.pressed_pulse,
               want.released_pulse, want.history_bits, got.debounced_level,
               got.pressed_pulse, got.released_pulse, got.history_bits);
  endfunction

  // Driver: offers queued samples, predicts each accepted word
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid     <= 1'b0;
      sample_if.raw_level <= 1'b0;
      src_gap             <= 0;
    end else begin
      if (sample_if.valid && sample_if.ready)
        predicted_words.push_back(debounce_tick(sample_if.raw_level));
      if (!sample_if.valid || sample_if.ready) begin
        if (src_gap > 0) begin
          sample_if.valid <= 1'b0;
          src_gap         <= src_gap - 1;
        end else if (raw_samples.size() > 0) begin
          sample_if.valid     <= 1'b1;
          sample_if.raw_level <= raw_samples.pop_front();
          if (idle_on && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 7);
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted word against the oldest prediction
  always @(posedge clk) begin : monitor
    cgd_pkg::result_t got_word;
    cgd_pkg::result_t want_word;
    if (rst) begin
      result_if.ready <= 1'b0;
      snk_gap         <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got_word = {result_if.debounced_level, result_if.pressed_pulse,
                    result_if.released_pulse, result_if.history_bits};
        if (predicted_words.size() == 0) begin
          log_mismatch("unexpected word", '0, got_word);
        end else begin
          want_word = predicted_words.pop_front();
          if (got_word.debounced_level !== want_word.debounced_level ||
              got_word.pressed_pulse   !== want_word.pressed_pulse ||
              got_word.released_pulse  !== want_word.released_pulse ||
              got_word.history_bits    !== want_word.history_bits)
            log_mismatch("word mismatch", want_word, got_word);
        end
      end
      if (sink_hold) begin
        result_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        result_if.ready <= 1'b0;
        snk_gap         <= snk_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_if.ready <= 1'b0;
        snk_gap         <= $urandom_range(0, 6);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Waits until every sample is taken and every word checked, then settles
  task automatic wait_drained();
    while (raw_samples.size() != 0 || sample_if.valid || predicted_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cgd_pkg::cfg_reg_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      cgd_pkg::REG_EDGE_LIMIT:      thr_cfg     = val[3:0];
      cgd_pkg::REG_CHATTER_CONFIRM: confirm_cfg = val;
      cgd_pkg::REG_RECENTER_TICKS:  timeout_cfg = val;
      cgd_pkg::REG_WINDOW_LEN:      window_cfg  = val[3:0];
      cgd_pkg::REG_START_LEVEL:     load_level(val[0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int thr, input int confirm, input int tmo,
                            input int win, input logic lvl);
    write_reg(cgd_pkg::REG_EDGE_LIMIT, 8'(thr));
    write_reg(cgd_pkg::REG_CHATTER_CONFIRM, 8'(confirm));
    write_reg(cgd_pkg::REG_RECENTER_TICKS, 8'(tmo));
    write_reg(cgd_pkg::REG_WINDOW_LEN, 8'(win));
    write_reg(cgd_pkg::REG_START_LEVEL, {7'd0, lvl});
  endtask

  task automatic push_run(input logic v, input int n);
    repeat (n) raw_samples.push_back(v);
  endtask

  task automatic push_chatter(input logic first, input int n);
    for (int i = 0; i < n; i++) raw_samples.push_back(first ^ i[0]);
  endtask

  // Mostly press/release gestures (bounce then a stable run), some noise and
  // long chatter bursts that drive the gate and the recentering
  task automatic push_gestures(input int count);
    int   start_size;
    int   pick;
    logic lvl;
    start_size = raw_samples.size();
    lvl = 1'($urandom_range(0, 1));
    while (raw_samples.size() - start_size < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        lvl = ~lvl;
        repeat ($urandom_range(0, 6)) raw_samples.push_back(1'($urandom_range(0, 1)));
        push_run(lvl, $urandom_range(1, 12));
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 8)) raw_samples.push_back(1'($urandom_range(0, 1)));
      end else begin
        push_chatter(1'($urandom_range(0, 1)), $urandom_range(4, 30));
      end
    end
  endtask

  initial begin
    sample_if.valid     = 1'b0;
    sample_if.raw_level = 1'b0;
    result_if.ready     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: clean press, clean release, chatter gating, settle after chatter
    push_run(1'b1, 4);
    push_run(1'b0, 4);
    push_chatter(1'b1, 9);
    push_run(1'b1, 8);
    wait_drained();

    // Long sink hold-off while the sender keeps offering words
    set_config(3, 2, 50, 4, 1'b1);
    @(posedge clk);
    sink_hold <= 1'b1;
    push_gestures(50);
    repeat (150) @(posedge clk);
    sink_hold <= 1'b0;
    wait_drained();

    // Extreme settings
    set_config(8, 0, 1, 1, 1'b0);
    push_gestures(30);
    wait_drained();
    set_config(8, 255, 255, 8, 1'b0);
    push_gestures(40);
    wait_drained();
    set_config(8, 1, 1, 0, 1'b1);
    push_gestures(30);
    wait_drained();
    set_config(3, 2, 0, 4, 1'b0);
    push_gestures(30);
    wait_drained();
    set_config(2, 1, 5, 2, 1'b0);
    push_gestures(40);
    wait_drained();
    set_config(7, 3, 10, 3, 1'b1);
    push_gestures(40);
    wait_drained();

    // Every tick chatters: chatter run saturates, recentering is not reached; no idling
    @(posedge clk);
    idle_on <= 1'b0;
    set_config(0, 200, 255, 5, 1'b0);
    repeat (260) raw_samples.push_back(1'($urandom_range(0, 1)));
    wait_drained();
    @(posedge clk);
    idle_on <= 1'b1;

    // Random settings
    repeat (2) begin
      set_config($urandom_range(0, 8), $urandom_range(0, 12), $urandom_range(1, 60),
                 $urandom_range(1, 8), 1'($urandom_range(0, 1)));
      push_gestures(50);
      wait_drained();
    end

    // Last part with no idling
    @(posedge clk);
    idle_on <= 1'b0;
    set_config($urandom_range(1, 7), $urandom_range(1, 6), $urandom_range(8, 40),
               $urandom_range(2, 6), 1'($urandom_range(0, 1)));
    push_gestures(50);
    wait_drained();
    repeat (8) @(posedge clk);

    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
sv/cgd_pkg.sv
sv/cgd_sample_if.sv
sv/cgd_result_if.sv
sv/cgd_cfg_regs.sv
sv/cgd_core.sv
sv/chatter_gated_debouncer_unit.sv
verif/tb_chatter_gated_debouncer_unit.sv
